// ----- src/custom_alphabet_radix_converter_macros.svh -----
// Assertion macros shared by the checker files of the radix converter.
// No dependencies.
`ifndef CUSTOM_ALPHABET_RADIX_CONVERTER_MACROS_SVH
`define CUSTOM_ALPHABET_RADIX_CONVERTER_MACROS_SVH

// Implication checked on every edge outside reset
`define CARC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define CARC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/carc_pkg.sv -----
// Shared types and constants of the radix converter.
// No dependencies.
`default_nettype none
package carc_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam int         DIGIT_SLOTS = 32;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_SRC_LO  = 3'd0;
  localparam logic [2:0] REG_SRC_HI  = 3'd1;
  localparam logic [2:0] REG_SRC_CNT = 3'd2;
  localparam logic [2:0] REG_TGT_LO  = 3'd3;
  localparam logic [2:0] REG_TGT_HI  = 3'd4;
  localparam logic [2:0] REG_TGT_CNT = 3'd5;

  // Parse phases
  localparam logic [1:0] PH_SPACE   = 2'd0;
  localparam logic [1:0] PH_DIGITS  = 2'd1;
  localparam logic [1:0] PH_STOP_OK = 2'd2;
  localparam logic [1:0] PH_STOP_BAD = 2'd3;

  typedef enum logic [2:0] {
    ST_PARSE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT,
    ST_NOOUT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic parse_char;   // apply one character
    logic check_start;  // start alphabet checks
    logic check_step;   // one alphabet check slot
    logic div_start;    // load magnitude
    logic div_step;     // one quotient bit
    logic emit_pop;     // a digit word was taken
  } carc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic check_done;
    logic tgt_ok;
    logic negative;
    logic div_done;     // all digits extracted
    logic last_digit;   // one digit left in the buffer
  } carc_sts_t;

endpackage
`default_nettype wire

// ----- src/custom_alphabet_radix_converter.sv -----
// Top level of the radix converter: controller plus datapath.
// Uses carc_pkg, carc_ctrl and carc_datapath.
`default_nettype none
// Characters are taken one per cycle while the input is not stalled, each a
// single multiply-add into the accumulator. The end word stalls the input
// for the alphabet checks. The serial divider then extracts the output digits
// one quotient bit at a time, up to 32 digits for VALUE_BITS=32. Digits then
// leave one per cycle while out_stall is low, the sign first when negative.
// An invalid target alphabet gives one word with no_output set.
module custom_alphabet_radix_converter
  import carc_pkg::*;
#(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_symbol,
  input  wire logic        in_end_of_string,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_symbol,
  output logic             out_final_symbol,
  output logic             out_no_output
);

  carc_cmd_t cmd;
  carc_sts_t sts;
  logic      is_sign, is_noout;

  assign cfg_ready = 1'b1;

  carc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_end(in_end_of_string), .in_stall,
    .out_valid, .out_stall, .out_is_sign(is_sign), .out_is_noout(is_noout),
    .cmd, .sts
  );

  carc_datapath #(.MAX_RADIX(MAX_RADIX), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst_n, .cfg_we(cfg_valid), .cfg_sel(cfg_index), .cfg_data,
    .in_symbol, .out_is_sign(is_sign), .out_is_noout(is_noout),
    .out_symbol, .out_final_symbol, .out_no_output, .cmd, .sts
  );

endmodule
`default_nettype wire

// ----- src/carc_ctrl.sv -----
// Controller state machine of the radix converter.
// Uses carc_pkg.
`default_nettype none
module carc_ctrl
  import carc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_end,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output logic           out_is_sign,
  output logic           out_is_noout,
  output carc_cmd_t      cmd,
  input  wire carc_sts_t sts
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PARSE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_PARSE: begin
        if (in_valid && in_end) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.check_done) begin
          if (!sts.tgt_ok) state_nxt = ST_NOOUT;
          else state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (sts.div_done) state_nxt = sts.negative ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (!out_stall) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall && sts.last_digit) state_nxt = ST_PARSE;
      end
      ST_NOOUT: begin
        if (!out_stall) state_nxt = ST_PARSE;
      end
      default: state_nxt = ST_PARSE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    out_is_sign  = 1'b0;
    out_is_noout = 1'b0;
    case (state_r)
      ST_PARSE: begin
        in_stall        = 1'b0;
        cmd.parse_char  = in_valid && !in_end;
        cmd.check_start = in_valid && in_end;
      end
      ST_CHECK: begin
        cmd.check_step = 1'b1;
        cmd.div_start  = sts.check_done;
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_SIGN: begin
        out_valid   = 1'b1;
        out_is_sign = 1'b1;
      end
      ST_EMIT: begin
        out_valid    = 1'b1;
        cmd.emit_pop = !out_stall;
      end
      ST_NOOUT: begin
        out_valid    = 1'b1;
        out_is_noout = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/carc_datapath.sv -----
// Datapath of the radix converter: parser, alphabet checks, divider, digit stack.
// Uses carc_pkg.
`default_nettype none
module carc_datapath
  import carc_pkg::*;
#(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_sel,
  input  wire logic [63:0] cfg_data,
  input  wire logic [7:0] in_symbol,
  input  wire logic       out_is_sign,
  input  wire logic       out_is_noout,
  output logic [7:0]      out_symbol,
  output logic            out_final_symbol,
  output logic            out_no_output,
  input  wire carc_cmd_t  cmd,
  output carc_sts_t       sts
);

  localparam int SLOT_W = 4;
  localparam int CNT_W  = $clog2(DIGIT_SLOTS + 1);
  localparam int VB_W   = $clog2(VALUE_BITS + 1);
  localparam logic [4:0] MAX_R = 5'(MAX_RADIX);

  // Configuration registers
  logic [127:0] src_sym_r, tgt_sym_r;
  logic [4:0]   src_cnt_r, tgt_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_sym_r <= '0;
      tgt_sym_r <= '0;
      src_cnt_r <= '0;
      tgt_cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_SRC_LO:  src_sym_r[63:0]   <= cfg_data;
        REG_SRC_HI:  src_sym_r[127:64] <= cfg_data;
        REG_SRC_CNT: src_cnt_r         <= cfg_data[4:0];
        REG_TGT_LO:  tgt_sym_r[63:0]   <= cfg_data;
        REG_TGT_HI:  tgt_sym_r[127:64] <= cfg_data;
        REG_TGT_CNT: tgt_cnt_r         <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [4:0] src_rad, tgt_rad;
  assign src_rad = (src_cnt_r > MAX_R) ? MAX_R : src_cnt_r;
  assign tgt_rad = (tgt_cnt_r > MAX_R) ? MAX_R : tgt_cnt_r;

  // Source lookup: first matching slot
  logic       hit;
  logic [3:0] hit_idx;
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (5'(i) < src_rad && src_sym_r[8*i +: 8] == in_symbol) begin
        hit     = 1'b1;
        hit_idx = 4'(i);
      end
    end
  end

  // Parser
  logic [1:0]            phase_r;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] acc_r;
  logic                  is_ws, is_sign;
  assign is_ws   = in_symbol == CH_SPACE || (in_symbol >= CH_TAB && in_symbol <= CH_CR);
  assign is_sign = in_symbol == CH_PLUS || in_symbol == CH_MINUS;

  logic [VALUE_BITS+4:0] mac;
  assign mac = acc_r * src_rad + (VALUE_BITS+5)'(hit_idx);

  // Alphabet checks: one slot per cycle against all earlier slots
  logic [4:0] chk_i_r;
  logic       src_ok_r, tgt_ok_r, chk_done_r;
  logic       src_bad, tgt_bad;
  always_comb begin
    src_bad = src_sym_r[8*chk_i_r[3:0] +: 8] == CH_PLUS
           || src_sym_r[8*chk_i_r[3:0] +: 8] == CH_MINUS;
    tgt_bad = tgt_sym_r[8*chk_i_r[3:0] +: 8] == CH_PLUS
           || tgt_sym_r[8*chk_i_r[3:0] +: 8] == CH_MINUS;
    for (int j = 0; j < 16; j++) begin
      if (5'(j) < chk_i_r) begin
        if (src_sym_r[8*j +: 8] == src_sym_r[8*chk_i_r[3:0] +: 8]) src_bad = 1'b1;
        if (tgt_sym_r[8*j +: 8] == tgt_sym_r[8*chk_i_r[3:0] +: 8]) tgt_bad = 1'b1;
      end
    end
  end

  logic src_valid, value_zero;
  logic [VALUE_BITS-1:0] val, mag;
  assign src_valid  = src_ok_r && src_rad >= 5'd2;
  assign value_zero = phase_r == PH_STOP_BAD || !src_valid;
  assign val = value_zero ? '0 : (neg_r ? (~acc_r + 1'b1) : acc_r);
  assign mag = val[VALUE_BITS-1] ? (~val + 1'b1) : val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SPACE;
      neg_r      <= 1'b0;
      acc_r      <= '0;
      chk_done_r <= 1'b0;
      chk_i_r    <= '0;
      src_ok_r   <= 1'b1;
      tgt_ok_r   <= 1'b1;
    end else begin
      if (cmd.parse_char) begin
        if (phase_r == PH_SPACE && is_sign) begin
          neg_r   <= in_symbol == CH_MINUS;
          phase_r <= PH_DIGITS;
        end else if ((phase_r == PH_SPACE && !is_ws) || phase_r == PH_DIGITS) begin
          if (hit) begin
            acc_r   <= mac[VALUE_BITS-1:0];
            phase_r <= PH_DIGITS;
          end else if (is_sign || in_symbol == 8'd0) begin
            phase_r <= PH_STOP_OK;
          end else begin
            phase_r <= PH_STOP_BAD;
          end
        end
      end
      if (cmd.check_start) begin
        chk_i_r    <= '0;
        chk_done_r <= 1'b0;
        src_ok_r   <= 1'b1;
        tgt_ok_r   <= 1'b1;
      end else if (cmd.check_step && !chk_done_r) begin
        if (chk_i_r < src_rad && src_bad) src_ok_r <= 1'b0;
        if (chk_i_r < tgt_rad && tgt_bad) tgt_ok_r <= 1'b0;
        chk_i_r <= chk_i_r + 5'd1;
        if (chk_i_r == 5'd15) chk_done_r <= 1'b1;
      end
      // Parser returns to reset once the divider has loaded the value
      if (cmd.div_start) begin
        phase_r <= PH_SPACE;
        neg_r   <= 1'b0;
        acc_r   <= '0;
      end
    end
  end

  assign sts.check_done = chk_done_r;
  assign sts.tgt_ok     = tgt_ok_r && tgt_rad >= 5'd2;

  // Restoring divider, one quotient bit per cycle
  logic [VALUE_BITS-1:0] quo_r;
  logic [4:0]            rem_r;
  logic [VB_W-1:0]       bit_r;
  logic                  dig_busy_r, neg_out_r, div_done_r;
  logic [CNT_W-1:0]      nd_r;
  logic [SLOT_W-1:0]     dbuf [DIGIT_SLOTS];
  logic [5:0]            trial;
  assign trial = {rem_r, quo_r[VALUE_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_busy_r <= 1'b0;
      div_done_r <= 1'b0;
      nd_r       <= '0;
      neg_out_r  <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        quo_r      <= mag;
        rem_r      <= '0;
        bit_r      <= '0;
        nd_r       <= '0;
        neg_out_r  <= val[VALUE_BITS-1];
        dig_busy_r <= 1'b1;
        div_done_r <= 1'b0;
      end else if (cmd.div_step && dig_busy_r) begin
        if (bit_r == VB_W'(VALUE_BITS)) begin
          // one digit finished: push remainder
          dbuf[nd_r[4:0]] <= rem_r[3:0];
          nd_r  <= nd_r + 1'b1;
          rem_r <= '0;
          bit_r <= '0;
          if (quo_r == '0 || nd_r == CNT_W'(DIGIT_SLOTS - 1)) begin
            dig_busy_r <= 1'b0;
            div_done_r <= 1'b1;
          end
        end else begin
          if (trial >= {1'b0, tgt_rad}) begin
            rem_r <= 5'(trial - {1'b0, tgt_rad});
            quo_r <= {quo_r[VALUE_BITS-2:0], 1'b1};
          end else begin
            rem_r <= trial[4:0];
            quo_r <= {quo_r[VALUE_BITS-2:0], 1'b0};
          end
          bit_r <= bit_r + 1'b1;
        end
      end else if (cmd.emit_pop) begin
        nd_r <= nd_r - 1'b1;
        div_done_r <= 1'b0;
      end
    end
  end

  assign sts.div_done   = div_done_r;
  assign sts.negative   = neg_out_r;
  assign sts.last_digit = nd_r == CNT_W'(1);

  // Output word
  logic [CNT_W-1:0] top;
  logic [3:0]       d;
  assign top = nd_r - 1'b1;
  assign d   = dbuf[top[4:0]];
  always_comb begin
    if (out_is_noout) begin
      out_symbol = '0;
      out_final_symbol = 1'b1;
      out_no_output = 1'b1;
    end else if (out_is_sign) begin
      out_symbol = CH_MINUS;
      out_final_symbol = 1'b0;
      out_no_output = 1'b0;
    end else begin
      out_symbol = tgt_sym_r[8*d +: 8];
      out_final_symbol = sts.last_digit;
      out_no_output = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- src/carc_checker.sv -----
// Port-level checker for the radix converter, bound to the top level.
// Uses custom_alphabet_radix_converter_macros.svh.
`default_nettype none
`include "custom_alphabet_radix_converter_macros.svh"
module carc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_end_of_string,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_symbol,
  input wire logic       out_final_symbol,
  input wire logic       out_no_output
);
  // No input is taken while results are shown
  `CARC_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, in_stall, "input taken during output")
  // A no-output word always ends the string
  `CARC_ASSERT_IMP(a_noout_final, clk, rst_n, out_valid && out_no_output, out_final_symbol,
    "no_output without final")
  // An end word stalls the input next cycle
  `CARC_ASSERT_NXT(a_end_stall, clk, rst_n, in_valid && !in_stall && in_end_of_string,
    in_stall, "input open after end word")
  // Held output word stays put
  `CARC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_symbol), "stalled word changed")
endmodule

bind custom_alphabet_radix_converter carc_checker u_chk (.*);
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the custom alphabet radix converter.
// Depends on carc_pkg and custom_alphabet_radix_converter; drives strings and alphabets.
`default_nettype none
module tb_top;
  import carc_pkg::*;

  localparam int RADIX_CAP  = 16;
  localparam int WORD_BITS  = 32;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef struct packed {
    logic [7:0] symbol;
    logic       eos;
  } char_word_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
    logic       no_output;
  } digit_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_SRC_LO;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_symbol = '0;
  logic in_end_of_string = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_symbol;
  logic out_final_symbol;
  logic out_no_output;

  custom_alphabet_radix_converter dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_symbol(in_symbol),
    .in_end_of_string(in_end_of_string),
    .out_valid(out_valid), .out_stall(out_stall), .out_symbol(out_symbol),
    .out_final_symbol(out_final_symbol), .out_no_output(out_no_output)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: registers and parser
  logic [63:0] src_lo, src_hi, tgt_lo, tgt_hi;
  logic [4:0] src_cnt, tgt_cnt;
  logic [1:0] phase;
  logic neg_flag;
  logic [WORD_BITS-1:0] acc;

  char_word_t pending_chars[$];
  digit_word_t expected_digits[$];
  int mismatches = 0;
  int digits_seen = 0;
  int strings_sent = 0;
  bit quiet = 1'b0;       // no idling stretch
  bit hold_chars = 1'b0;  // sender pause
  bit in_taken = 1'b0;    // input word accepted at the last rising edge

  function automatic int radix_of(logic [4:0] cnt);
    return (cnt > RADIX_CAP) ? RADIX_CAP : int'(cnt);
  endfunction

  function automatic logic [7:0] sym_at(logic [63:0] lo, logic [63:0] hi, int i);
    return (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
  endfunction

  function automatic int find_digit(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt,
                                    logic [7:0] c);
    int n;
    n = radix_of(cnt);
    for (int i = 0; i < n; i++)
      if (sym_at(lo, hi, i) == c) return i;
    return -1;
  endfunction

  function automatic bit alphabet_valid(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt);
    int n;
    logic [7:0] s;
    n = radix_of(cnt);
    if (n < 2) return 1'b0;
    for (int i = 0; i < n; i++) begin
      s = sym_at(lo, hi, i);
      if (s == CH_PLUS || s == CH_MINUS) return 1'b0;
      for (int j = 0; j < i; j++)
        if (sym_at(lo, hi, j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // one character in the digit phase
  task automatic take_digit(logic [7:0] c);
    int d;
    d = find_digit(src_lo, src_hi, src_cnt, c);
    if (d >= 0) begin
      acc = acc * WORD_BITS'(radix_of(src_cnt)) + WORD_BITS'(d);
      phase = PH_DIGITS;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_NUL) begin
      phase = PH_STOP_OK;
    end else begin
      phase = PH_STOP_BAD;
    end
  endtask

  // parse one accepted word, queue the converted string at the end marker
  task automatic convert_char(char_word_t w);
    logic [WORD_BITS-1:0] v, mag;
    int r, nd;
    int digs[$];
    if (!w.eos) begin
      if (phase == PH_SPACE) begin
        if (is_blank(w.symbol)) return;
        if (w.symbol == CH_PLUS || w.symbol == CH_MINUS) begin
          neg_flag = (w.symbol == CH_MINUS);
          phase = PH_DIGITS;
          return;
        end
        take_digit(w.symbol);
      end else if (phase == PH_DIGITS) begin
        take_digit(w.symbol);
      end
      return;
    end
    v = acc;
    if (phase == PH_STOP_BAD || !alphabet_valid(src_lo, src_hi, src_cnt)) v = '0;
    if (neg_flag) v = -v;
    phase = PH_SPACE;
    neg_flag = 1'b0;
    acc = '0;
    if (!alphabet_valid(tgt_lo, tgt_hi, tgt_cnt)) begin
      expected_digits.push_back('{8'h00, 1'b1, 1'b1});
      return;
    end
    r = radix_of(tgt_cnt);
    mag = v;
    if (v[WORD_BITS-1]) begin
      mag = -v;
      expected_digits.push_back('{CH_MINUS, 1'b0, 1'b0});
    end
    nd = 0;
    do begin
      digs.push_front(int'(mag % WORD_BITS'(r)));
      mag = mag / WORD_BITS'(r);
      nd++;
    end while (mag != 0 && nd < DIGIT_SLOTS);
    foreach (digs[k])
      expected_digits.push_back('{sym_at(tgt_lo, tgt_hi, digs[k]),
                                  k == digs.size() - 1, 1'b0});
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold stalled word
      end else if (pending_chars.size() > 0 && !hold_chars &&
                   (quiet || $urandom_range(99) >= 14)) begin
        in_valid <= 1'b1;
        in_symbol <= pending_chars[0].symbol;
        in_end_of_string <= pending_chars[0].eos;
        void'(pending_chars.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 14);
    end
  end

  // monitor: predict on accepted input, check each result word
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        convert_char('{in_symbol, in_end_of_string});
      if (out_valid && !out_stall) begin
        digits_seen++;
        if (expected_digits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word sym=%h final=%b none=%b",
                     out_symbol, out_final_symbol, out_no_output);
        end else begin
          digit_word_t e;
          e = expected_digits.pop_front();
          if (e.symbol !== out_symbol || e.final_symbol !== out_final_symbol ||
              e.no_output !== out_no_output) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp sym=%h final=%b none=%b, got sym=%h final=%b none=%b",
                       e.symbol, e.final_symbol, e.no_output,
                       out_symbol, out_final_symbol, out_no_output);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SRC_LO:  src_lo = data;
      REG_SRC_HI:  src_hi = data;
      REG_SRC_CNT: src_cnt = data[4:0];
      REG_TGT_LO:  tgt_lo = data;
      REG_TGT_HI:  tgt_hi = data;
      REG_TGT_CNT: tgt_cnt = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until the block has drained
  task automatic drain;
    while (pending_chars.size() > 0 || in_valid || expected_digits.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_alphabets(logic [63:0] slo, logic [63:0] shi, logic [4:0] scnt,
                               logic [63:0] tlo, logic [63:0] thi, logic [4:0] tcnt);
    drain();
    write_reg(REG_SRC_LO, slo);
    write_reg(REG_SRC_HI, shi);
    write_reg(REG_SRC_CNT, {59'd0, scnt});
    write_reg(REG_TGT_LO, tlo);
    write_reg(REG_TGT_HI, thi);
    write_reg(REG_TGT_CNT, {59'd0, tcnt});
  endtask

  task automatic push_char(logic [7:0] c);
    pending_chars.push_back('{c, 1'b0});
  endtask

  task automatic push_end(logic [7:0] c);
    pending_chars.push_back('{c, 1'b1});
    strings_sent++;
  endtask

  // random string: mostly well formed with alphabet digits
  task automatic push_number(int len);
    int n, pick;
    n = radix_of(src_cnt);
    if ($urandom_range(3) == 0) push_char($urandom_range(1) ? CH_SPACE : CH_TAB);
    pick = $urandom_range(3);
    if (pick == 0) push_char(CH_MINUS);
    else if (pick == 1) push_char(CH_PLUS);
    for (int i = 0; i < len; i++) begin
      if (n > 0 && $urandom_range(9) != 0) push_char(sym_at(src_lo, src_hi, $urandom_range(n-1)));
      else push_char(8'($urandom_range(255)));
    end
    push_end(8'($urandom_range(255)));
  endtask

  localparam logic [63:0] HEX_LO = 64'h3736353433323130;  // "01234567"
  localparam logic [63:0] HEX_HI = 64'h6665646362613938;  // "89abcdef"

  initial begin
    int len;
    string num_str;
    src_lo = '0; src_hi = '0; tgt_lo = '0; tgt_hi = '0; src_cnt = '0; tgt_cnt = '0;
    phase = PH_SPACE; neg_flag = 1'b0; acc = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // invalid alphabets after reset: single empty word
    push_char(8'h31); push_end(8'h00);
    quiet = 1'b1;

    // decimal to hex, directed
    set_alphabets(HEX_LO, 64'h3938, 5'd10, HEX_LO, HEX_HI, 5'd16);
    push_char(CH_SPACE); push_char(CH_TAB); push_char(CH_MINUS);
    num_str = "2147483648";
    foreach (num_str[i]) push_char(num_str[i]);
    push_end(8'hFF);
    num_str = "4294967295";
    foreach (num_str[i]) push_char(num_str[i]);
    push_end(8'h00);
    push_char(CH_PLUS); push_char(8'h30); push_end(8'h00);
    push_char(8'h37); push_char(CH_MINUS); push_char(8'h39); push_end(8'h00);
    push_char(8'h37); push_char(8'h78); push_char(8'h39); push_end(8'h00);
    push_char(8'h31); push_char(8'h00); push_end(8'h00);
    push_end(8'h00);
    quiet = 1'b0;

    // source count above cap (invalid source), binary target, all ones on the registers
    set_alphabets(HEX_LO, 64'h3938, 5'd31, 64'h3130, '1, 5'd2);
    push_char(CH_MINUS); push_char(8'h31); push_char(8'h66); push_end(8'h00);
    num_str = "99999999999";
    foreach (num_str[i]) push_char(num_str[i]);
    push_end(8'h00);
    // source with a sign, target with a duplicate
    set_alphabets(64'h2B30, '0, 5'd2, 64'h3030, '0, 5'd2);
    push_char(8'h30); push_end(8'h00);
    // byte 0 as a source digit, hex target
    set_alphabets(64'h0031, '0, 5'd2, HEX_LO, HEX_HI, 5'd16);
    push_char(8'h31); push_char(8'h00); push_char(8'h31); push_end(8'h00);

    // random phases
    for (int p = 0; p < 6; p++) begin
      logic [63:0] perm_lo, perm_hi;
      logic [7:0] syms[16];
      for (int i = 0; i < 16; i++) syms[i] = 8'h41 + 8'(i) + 8'(p * 16);
      syms.shuffle();
      for (int i = 0; i < 8; i++) begin
        perm_lo[8*i +: 8] = syms[i];
        perm_hi[8*i +: 8] = syms[i+8];
      end
      if (p == 5) set_alphabets(64'($urandom), 64'($urandom), 5'($urandom_range(31)),
                                {$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
      else set_alphabets(perm_lo, perm_hi, 5'($urandom_range(2, 16)),
                         HEX_LO, HEX_HI, p == 0 ? 5'd2 : 5'($urandom_range(2, 16)));
      if (p == 2) quiet = 1'b1;
      for (int s = 0; s < 6; s++) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
        push_number(len);
        if (s == 3) begin
          while (pending_chars.size() > 0) @(posedge clk);
          hold_chars = 1'b1;
          while (in_valid || expected_digits.size() > 0) @(posedge clk);
          hold_chars = 1'b0;
        end
      end
      quiet = 1'b0;
    end
    drain();
    $display("Converted %0d strings into %0d output words over several alphabet settings.",
             strings_sent, digits_seen);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+src
src/carc_pkg.sv
src/carc_ctrl.sv
src/carc_datapath.sv
src/custom_alphabet_radix_converter.sv
src/carc_checker.sv
verif/tb_top.sv
